>>> sv/rsa_keygen_encrypt_decrypt_unit_assert.svh
// ----------------------------------------------------------------------------
// rsa keygen unit assertion macros
// shared property forms for the controller checks
// ----------------------------------------------------------------------------
`ifndef RSA_KEYGEN_ENCRYPT_DECRYPT_UNIT_ASSERT_SVH
`define RSA_KEYGEN_ENCRYPT_DECRYPT_UNIT_ASSERT_SVH

// same-cycle implication
`define RSAKG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RSAKG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/rsakg_pkg.sv
// ----------------------------------------------------------------------------
// rsakg_pkg
// shared types and constants of the rsa key generation unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsakg_pkg;

  localparam int PRIME_BITS_DEF = 8;
  localparam int FIELD_W        = 16;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_PRODUCTS,
    OP_GCD_INIT,
    OP_GCD_DIV,
    OP_GCD_STEP,
    OP_E_INC,
    OP_INV_INIT,
    OP_INV_DIV,
    OP_INV_MUL,
    OP_INV_UPD,
    OP_INV_DONE,
    OP_PW_INIT,
    OP_PW_BASE,
    OP_PW_MUL,
    OP_PW_STEP,
    OP_PW_END,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic dec;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic mm_done;
    logic gb_zero;
    logic ga_one;
    logic e_lt_phi;
    logic phi_ge2;
    logic x_gt1;
    logic y_nz;
    logic n_zero;
    logic ex_zero;
  } sts_t;

endpackage

`default_nettype wire

>>> sv/rsa_keygen_encrypt_decrypt_unit.sv
// ----------------------------------------------------------------------------
// rsa_keygen_encrypt_decrypt_unit
// textbook rsa key pair and round trip on a small modulus
// ----------------------------------------------------------------------------
// in_* takes one item: primes p, q and a message. out_* returns e, d, n,
// the ciphertext and the decrypted value. One item is worked on at a time;
// the next is taken once the current result is in the output register, so
// a finished result may wait for out_tready while a new item is accepted.
// Every step runs on a DW-bit restoring divider or two interleaved modular
// multipliers, DW = max(2*PRIME_BITS,16). Latency grows with the gcd steps
// of the exponent search, the euclid steps and the bit lengths of e and d,
// set by the shared divider and the multiplier loop.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// out_tvalid. A stalled receiver holds out_tvalid and out_tdata steady; the
// sequencer then waits in its final state before loading the next result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsa_keygen_encrypt_decrypt_unit #(
  parameter int PRIME_BITS = rsakg_pkg::PRIME_BITS_DEF
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     in_tvalid,
  output logic                                          in_tready,
  // prime_p, prime_q, message, zero pad
  input  wire logic [((2*PRIME_BITS+16+7)/8)*8-1:0]     in_tdata,
  output logic                                          out_tvalid,
  input  wire logic                                     out_tready,
  // public_exponent, private_exponent, modulus, ciphertext, recovered
  output logic [5*rsakg_pkg::FIELD_W-1:0]               out_tdata
);

  localparam int DW = (2 * PRIME_BITS > rsakg_pkg::FIELD_W) ? 2 * PRIME_BITS
                                                            : rsakg_pkg::FIELD_W;
  localparam int FW = rsakg_pkg::FIELD_W;

  rsakg_pkg::cmd_t cmd;
  rsakg_pkg::sts_t sts;
  logic [FW-1:0]   o_e, o_d, o_n, o_c, o_m;

  rsakg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  rsakg_dp #(.PRIME_BITS(PRIME_BITS), .DW(DW)) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .in_prime_p           (in_tdata[PRIME_BITS-1:0]),
    .in_prime_q           (in_tdata[2*PRIME_BITS-1:PRIME_BITS]),
    .in_message           (in_tdata[2*PRIME_BITS+FW-1:2*PRIME_BITS]),
    .sts                  (sts),
    .out_public_exponent  (o_e),
    .out_private_exponent (o_d),
    .out_modulus          (o_n),
    .out_ciphertext       (o_c),
    .out_recovered        (o_m)
  );

  assign out_tdata = {o_m, o_c, o_n, o_d, o_e};

endmodule

`default_nettype wire

>>> sv/rsakg_div.sv
// ----------------------------------------------------------------------------
// rsakg_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsakg_div #(
  parameter int DW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic      [DW-1:0] quotient,
  output logic      [DW-1:0] remainder,
  output logic               done
);

  localparam int CNT_W = (DW > 1) ? $clog2(DW) : 1;

  logic [DW-1:0]    quo_r, rem_r, dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DW:0]      trial, diff;
  logic             ge;

  assign trial = {rem_r, quo_r[DW-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
      cnt_r <= CNT_W'(DW - 1);
    end else if (busy_r) begin
      quo_r <= {quo_r[DW-2:0], ge};
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign done      = done_r;

endmodule

`default_nettype wire

>>> sv/rsakg_modmul.sv
// ----------------------------------------------------------------------------
// rsakg_modmul
// interleaved modular multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsakg_modmul #(
  parameter int DW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] mul_a,
  input  wire logic [DW-1:0] mul_b,
  input  wire logic [DW-1:0] modulus,
  output logic      [DW-1:0] product,
  output logic               done
);

  localparam int CNT_W = (DW > 1) ? $clog2(DW) : 1;

  logic [DW-1:0]    a_r, b_r, m_r, acc_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DW:0]      dbl, red1, add, red2;

  always_comb begin
    dbl  = {acc_r, 1'b0};
    red1 = (dbl >= {1'b0, m_r}) ? dbl - {1'b0, m_r} : dbl;
    add  = red1 + (a_r[DW-1] ? {1'b0, b_r} : '0);
    red2 = (add >= {1'b0, m_r}) ? add - {1'b0, m_r} : add;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= mul_a;
      b_r   <= mul_b;
      m_r   <= modulus;
      acc_r <= '0;
      cnt_r <= CNT_W'(DW - 1);
    end else if (busy_r) begin
      a_r   <= {a_r[DW-2:0], 1'b0};
      acc_r <= red2[DW-1:0];
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign product = acc_r;
  assign done    = done_r;

endmodule

`default_nettype wire

>>> sv/rsakg_dp.sv
// ----------------------------------------------------------------------------
// rsakg_dp
// datapath: key registers, shared divider and two modular multipliers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsakg_dp #(
  parameter int PRIME_BITS = rsakg_pkg::PRIME_BITS_DEF,
  parameter int DW         = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire rsakg_pkg::cmd_t                 cmd,
  input  wire logic [PRIME_BITS-1:0]           in_prime_p,
  input  wire logic [PRIME_BITS-1:0]           in_prime_q,
  input  wire logic [rsakg_pkg::FIELD_W-1:0]   in_message,
  output rsakg_pkg::sts_t                      sts,
  output logic [rsakg_pkg::FIELD_W-1:0]        out_public_exponent,
  output logic [rsakg_pkg::FIELD_W-1:0]        out_private_exponent,
  output logic [rsakg_pkg::FIELD_W-1:0]        out_modulus,
  output logic [rsakg_pkg::FIELD_W-1:0]        out_ciphertext,
  output logic [rsakg_pkg::FIELD_W-1:0]        out_recovered
);

  localparam int PW = 2 * PRIME_BITS;
  localparam int FW = rsakg_pkg::FIELD_W;

  logic [PRIME_BITS-1:0] p_r, q_r, pm1, qm1;
  logic [FW-1:0]         msg_r;
  logic [PW-1:0]         n_prod, phi_prod;
  logic [DW-1:0]         n_r, phi_r, e_r, d_r, c_r, m_r;
  logic [DW-1:0]         ga_r, gb_r, x_r, y_r, snew_r, sold_r;
  logic [DW-1:0]         acc_r, base_r, ex_r, sub_mod;
  logic [FW-1:0]         oe_r, od_r, on_r, oc_r, om_r;

  logic          div_start, mm0_start, mm1_start, div_done, mm0_done, mm1_done;
  logic [DW-1:0] div_a, div_b, div_q, div_r;
  logic [DW-1:0] mm0_a, mm0_b, mm0_m, mm0_p, mm1_p;
  logic          inv_mul;

  assign pm1      = (p_r != '0) ? p_r - PRIME_BITS'(1) : '0;
  assign qm1      = (q_r != '0) ? q_r - PRIME_BITS'(1) : '0;
  assign n_prod   = p_r * q_r;
  assign phi_prod = pm1 * qm1;

  assign div_start = (cmd.op == rsakg_pkg::OP_GCD_DIV) ||
                     (cmd.op == rsakg_pkg::OP_INV_DIV) ||
                     (cmd.op == rsakg_pkg::OP_PW_INIT);

  always_comb begin
    div_a = ga_r;
    div_b = gb_r;
    if (cmd.op == rsakg_pkg::OP_INV_DIV) begin
      div_a = x_r;
      div_b = y_r;
    end else if (cmd.op == rsakg_pkg::OP_PW_INIT) begin
      div_a = cmd.dec ? c_r : DW'(msg_r);
      div_b = n_r;
    end
  end

  assign inv_mul   = cmd.op == rsakg_pkg::OP_INV_MUL;
  assign mm1_start = cmd.op == rsakg_pkg::OP_PW_MUL;
  assign mm0_start = inv_mul || mm1_start;
  assign mm0_a     = inv_mul ? div_q  : acc_r;
  assign mm0_b     = inv_mul ? snew_r : base_r;
  assign mm0_m     = inv_mul ? phi_r  : n_r;

  // old s minus quotient times new s, kept in 0..phi-1
  assign sub_mod = (sold_r >= mm0_p) ? sold_r - mm0_p : sold_r + (phi_r - mm0_p);

  rsakg_div #(.DW(DW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .quotient  (div_q),
    .remainder (div_r),
    .done      (div_done)
  );

  rsakg_modmul #(.DW(DW)) u_mm_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mm0_start),
    .mul_a   (mm0_a),
    .mul_b   (mm0_b),
    .modulus (mm0_m),
    .product (mm0_p),
    .done    (mm0_done)
  );

  rsakg_modmul #(.DW(DW)) u_mm_sqr (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mm1_start),
    .mul_a   (base_r),
    .mul_b   (base_r),
    .modulus (n_r),
    .product (mm1_p),
    .done    (mm1_done)
  );

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      rsakg_pkg::OP_LOAD: begin
        p_r   <= in_prime_p;
        q_r   <= in_prime_q;
        msg_r <= in_message;
        e_r   <= DW'(2);
        d_r   <= '0;
        c_r   <= '0;
        m_r   <= '0;
      end
      rsakg_pkg::OP_PRODUCTS: begin
        n_r   <= DW'(n_prod);
        phi_r <= DW'(phi_prod);
      end
      rsakg_pkg::OP_GCD_INIT: begin
        ga_r <= e_r;
        gb_r <= phi_r;
      end
      rsakg_pkg::OP_GCD_STEP: begin
        ga_r <= gb_r;
        gb_r <= div_r;
      end
      rsakg_pkg::OP_E_INC: e_r <= e_r + DW'(1);
      rsakg_pkg::OP_INV_INIT: begin
        x_r    <= e_r;
        y_r    <= phi_r;
        snew_r <= '0;
        sold_r <= DW'(1);
      end
      rsakg_pkg::OP_INV_UPD: begin
        x_r    <= y_r;
        y_r    <= div_r;
        snew_r <= sub_mod;
        sold_r <= snew_r;
      end
      rsakg_pkg::OP_INV_DONE: d_r <= sold_r;
      rsakg_pkg::OP_PW_INIT: ex_r <= cmd.dec ? d_r : e_r;
      rsakg_pkg::OP_PW_BASE: begin
        base_r <= div_r;
        acc_r  <= (n_r == DW'(1)) ? '0 : DW'(1);
      end
      rsakg_pkg::OP_PW_STEP: begin
        if (ex_r[0]) begin
          acc_r <= mm0_p;
        end
        base_r <= mm1_p;
        ex_r   <= ex_r >> 1;
      end
      rsakg_pkg::OP_PW_END: begin
        if (cmd.dec) begin
          m_r <= acc_r;
        end else begin
          c_r <= acc_r;
        end
      end
      rsakg_pkg::OP_EMIT: begin
        oe_r <= e_r[FW-1:0];
        od_r <= d_r[FW-1:0];
        on_r <= n_r[FW-1:0];
        oc_r <= c_r[FW-1:0];
        om_r <= m_r[FW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sts.div_done = div_done;
    sts.mm_done  = mm0_done && mm1_done || (mm0_done && !mm1_done && inv_mul) ||
                   mm0_done;
    sts.gb_zero  = gb_r == '0;
    sts.ga_one   = ga_r == DW'(1);
    sts.e_lt_phi = e_r < phi_r;
    sts.phi_ge2  = phi_r >= DW'(2);
    sts.x_gt1    = x_r > DW'(1);
    sts.y_nz     = y_r != '0;
    sts.n_zero   = n_r == '0;
    sts.ex_zero  = ex_r == '0;
  end

  assign out_public_exponent  = oe_r;
  assign out_private_exponent = od_r;
  assign out_modulus          = on_r;
  assign out_ciphertext       = oc_r;
  assign out_recovered        = om_r;

endmodule

`default_nettype wire

>>> sv/rsakg_ctrl.sv
// ----------------------------------------------------------------------------
// rsakg_ctrl
// sequencer for key search, inverse and the two exponentiations
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rsa_keygen_encrypt_decrypt_unit_assert.svh"

module rsakg_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  input  wire rsakg_pkg::sts_t sts,
  output rsakg_pkg::cmd_t      cmd
);

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_PROD   = 16'h0002,
    S_GINIT  = 16'h0004,
    S_GTEST  = 16'h0008,
    S_GWAIT  = 16'h0010,
    S_GCHK   = 16'h0020,
    S_IINIT  = 16'h0040,
    S_ITEST  = 16'h0080,
    S_IDWAIT = 16'h0100,
    S_IMWAIT = 16'h0200,
    S_PSTART = 16'h0400,
    S_PIWAIT = 16'h0800,
    S_PTEST  = 16'h1000,
    S_PMWAIT = 16'h2000,
    S_DONE   = 16'h4000,
    S_SPARE  = 16'h8000
  } state_t;

  state_t state_r, state_nxt;
  logic   dec_r, dec_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   emit;

  always_comb begin
    state_nxt = state_r;
    dec_nxt   = dec_r;
    cmd.op    = rsakg_pkg::OP_NONE;
    cmd.dec   = dec_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = rsakg_pkg::OP_LOAD;
          state_nxt = S_PROD;
        end
      end
      S_PROD: begin
        cmd.op    = rsakg_pkg::OP_PRODUCTS;
        state_nxt = S_GINIT;
      end
      S_GINIT: begin
        cmd.op    = rsakg_pkg::OP_GCD_INIT;
        state_nxt = S_GTEST;
      end
      S_GTEST: begin
        if (sts.gb_zero) begin
          state_nxt = S_GCHK;
        end else begin
          cmd.op    = rsakg_pkg::OP_GCD_DIV;
          state_nxt = S_GWAIT;
        end
      end
      S_GWAIT: begin
        if (sts.div_done) begin
          cmd.op    = rsakg_pkg::OP_GCD_STEP;
          state_nxt = S_GTEST;
        end
      end
      S_GCHK: begin
        dec_nxt = 1'b0;
        priority if (sts.e_lt_phi && !sts.ga_one) begin
          cmd.op    = rsakg_pkg::OP_E_INC;
          state_nxt = S_GINIT;
        end else if (sts.phi_ge2 && sts.ga_one) begin
          state_nxt = S_IINIT;
        end else begin
          state_nxt = S_PSTART;
        end
      end
      S_IINIT: begin
        cmd.op    = rsakg_pkg::OP_INV_INIT;
        state_nxt = S_ITEST;
      end
      S_ITEST: begin
        if (sts.x_gt1 && sts.y_nz) begin
          cmd.op    = rsakg_pkg::OP_INV_DIV;
          state_nxt = S_IDWAIT;
        end else begin
          cmd.op    = rsakg_pkg::OP_INV_DONE;
          state_nxt = S_PSTART;
        end
      end
      S_IDWAIT: begin
        if (sts.div_done) begin
          cmd.op    = rsakg_pkg::OP_INV_MUL;
          state_nxt = S_IMWAIT;
        end
      end
      S_IMWAIT: begin
        if (sts.mm_done) begin
          cmd.op    = rsakg_pkg::OP_INV_UPD;
          state_nxt = S_ITEST;
        end
      end
      S_PSTART: begin
        if (sts.n_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.op    = rsakg_pkg::OP_PW_INIT;
          state_nxt = S_PIWAIT;
        end
      end
      S_PIWAIT: begin
        if (sts.div_done) begin
          cmd.op    = rsakg_pkg::OP_PW_BASE;
          state_nxt = S_PTEST;
        end
      end
      S_PTEST: begin
        if (sts.ex_zero) begin
          cmd.op = rsakg_pkg::OP_PW_END;
          if (dec_r) begin
            state_nxt = S_DONE;
          end else begin
            dec_nxt   = 1'b1;
            state_nxt = S_PSTART;
          end
        end else begin
          cmd.op    = rsakg_pkg::OP_PW_MUL;
          state_nxt = S_PMWAIT;
        end
      end
      S_PMWAIT: begin
        if (sts.mm_done) begin
          cmd.op    = rsakg_pkg::OP_PW_STEP;
          state_nxt = S_PTEST;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.op    = rsakg_pkg::OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign emit          = cmd.op == rsakg_pkg::OP_EMIT;
  assign out_valid_nxt = emit || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dec_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dec_r       <= dec_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = rst_n && (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  `RSAKG_ASSERT_NEXT(a_done_holds, state_r == S_DONE && out_valid_r && !out_tready, state_r == S_DONE, "result overwritten while stalled")
  `RSAKG_ASSERT_NEXT(a_div_to_mul, state_r == S_IDWAIT && sts.div_done, state_r == S_IMWAIT, "inverse multiply not started")
  `RSAKG_ASSERT_NEXT(a_mul_waits, state_r == S_PMWAIT && !sts.mm_done, state_r == S_PMWAIT, "power step left early")
  `RSAKG_ASSERT_NOW(a_valid_from_done, $rose(out_valid_r), $past(state_r) == S_DONE, "result shown outside done")

endmodule

`default_nettype wire
